// ===== rtl/hpqr_pkg.sv =====
`timescale 1ns / 1ps

package hpqr_pkg;

   // configuration port
   localparam int CFG_W       = 7;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAP_WIDTH  = 1'b0,
      CSR_MAP_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;
   localparam int               SIDE_MIN   = 3;

   // quarter-pixel coordinate width
   localparam int QUARTER_W = 8;

   function automatic int col_bits(input int max_side);
      col_bits = $clog2(max_side);
   endfunction

   function automatic int side_bits(input int max_side);
      side_bits = $clog2(max_side + 1);
   endfunction

   function automatic int addr_bits(input int max_side);
      addr_bits = $clog2(max_side * max_side);
   endfunction

   // address, column, row, score, error, positive, refine
   function automatic int job_bits(input int max_side, input int sample_bits);
      job_bits = addr_bits(max_side) + 2 * col_bits(max_side) + sample_bits + 3;
   endfunction

   // x, y, score, error
   function automatic int rsp_bits(input int sample_bits);
      rsp_bits = 2 * QUARTER_W + sample_bits + 1;
   endfunction

endpackage

// ===== rtl/heatmap_peak_quarter_refine_unit.sv =====
`timescale 1ns / 1ps

// channel   ports                                            handshake
// -------   -----------------------------------------------  -------------------------
// request   req_sample, req_last                             push & !full
// response  rsp_x_quarter, rsp_y_quarter, rsp_peak_score,    pop & !empty, head item
//           rsp_size_error
// config    csr_index, csr_data                              csr_write, no wait
//
// one sample per cycle unless full; the map goes to a single-port-write, single-port-read store
// a last item whose peak gets refined holds full high until the back end has drained earlier jobs
// and has read its four neighbors from the store
// a result passes the job queue, the back end (neighbor reads if refined) and the output queue
// full also rises when the job queue between front and back is full
// synchronous reset clears counters, peak and queues; the map store needs no clearing

module heatmap_peak_quarter_refine_unit #(
   parameter int MAX_SIDE    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [hpqr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hpqr_pkg::CFG_W-1:0]        csr_data,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  logic                              req_last,
   input  logic                              push,
   output logic                              full,
   output logic [hpqr_pkg::QUARTER_W-1:0]    rsp_x_quarter,
   output logic [hpqr_pkg::QUARTER_W-1:0]    rsp_y_quarter,
   output logic signed [SAMPLE_BITS-1:0]     rsp_peak_score,
   output logic                              rsp_size_error,
   output logic                              empty,
   input  logic                              pop
);
   import hpqr_pkg::*;

   localparam int ADDR_W = addr_bits(MAX_SIDE);
   localparam int JOB_W  = job_bits(MAX_SIDE, SAMPLE_BITS);
   localparam int RSP_W  = rsp_bits(SAMPLE_BITS);
   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;

   logic                   job_push;
   logic [JOB_W-1:0]       job_wdata;
   logic                   job_full;
   logic                   job_pop;
   logic [JOB_W-1:0]       job_rdata;
   logic                   job_empty;
   logic                   reads_done;
   logic                   refine_pending;
   logic                   store_we;
   logic [ADDR_W-1:0]      store_waddr;
   logic [SAMPLE_BITS-1:0] store_wdata;
   logic [ADDR_W-1:0]      store_raddr;
   logic [SAMPLE_BITS-1:0] store_rdata;
   logic                   res_push;
   logic [RSP_W-1:0]       res_data;
   logic                   res_full;
   logic [RSP_W-1:0]       rsp_word;

   hpqr_front #(
      .MAX_SIDE    (MAX_SIDE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .push           (push),
      .full           (full),
      .job_push       (job_push),
      .job_data       (job_wdata),
      .job_full       (job_full),
      .reads_done     (reads_done),
      .refine_pending (refine_pending),
      .store_we       (store_we),
      .store_waddr    (store_waddr),
      .store_wdata    (store_wdata)
   );

   hpqr_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wdata),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rdata),
      .empty   (job_empty)
   );

   hpqr_map_store #(
      .DEPTH (DEPTH),
      .WIDTH (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   hpqr_back #(
      .MAX_SIDE    (MAX_SIDE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job_data    (job_rdata),
      .job_pop     (job_pop),
      .store_raddr (store_raddr),
      .store_rdata (store_rdata),
      .reads_done  (reads_done),
      .res_push    (res_push),
      .res_data    (res_data),
      .res_full    (res_full)
   );

   hpqr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (rsp_word),
      .empty   (empty)
   );

   assign rsp_x_quarter  = rsp_word[RSP_W-1 -: QUARTER_W];
   assign rsp_y_quarter  = rsp_word[RSP_W-1-QUARTER_W -: QUARTER_W];
   assign rsp_peak_score = rsp_word[SAMPLE_BITS:1];
   assign rsp_size_error = rsp_word[0];

   a_job_room: assert property (@(posedge clock) disable iff (reset)
      !(job_push && job_full))
      else $error("job pushed into a full job queue");

   a_res_room: assert property (@(posedge clock) disable iff (reset)
      !(res_push && res_full))
      else $error("result pushed into a full output queue");

   a_reads_owned: assert property (@(posedge clock) disable iff (reset)
      reads_done |-> refine_pending)
      else $error("neighbor reads finished with no refine pending");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      refine_pending |-> !store_we)
      else $error("map store written while neighbor reads are pending");

endmodule

// ===== rtl/hpqr_fifo.sv =====
`timescale 1ns / 1ps

module hpqr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import hpqr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = p + 1'b1;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_rd) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/hpqr_map_store.sv =====
`timescale 1ns / 1ps

module hpqr_map_store #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import hpqr_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old entry when both ports hit the same address
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ===== rtl/hpqr_front.sv =====
`timescale 1ns / 1ps

module hpqr_front #(
   parameter int MAX_SIDE    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [hpqr_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [hpqr_pkg::CFG_W-1:0]               csr_data,
   input  logic signed [SAMPLE_BITS-1:0]            req_sample,
   input  logic                                     req_last,
   input  logic                                     push,
   output logic                                     full,
   output logic                                     job_push,
   output logic [hpqr_pkg::job_bits(MAX_SIDE, SAMPLE_BITS)-1:0] job_data,
   input  logic                                     job_full,
   input  logic                                     reads_done,
   output logic                                     refine_pending,
   output logic                                     store_we,
   output logic [hpqr_pkg::addr_bits(MAX_SIDE)-1:0] store_waddr,
   output logic [SAMPLE_BITS-1:0]                   store_wdata
);
   import hpqr_pkg::*;

   localparam int COL_W     = col_bits(MAX_SIDE);
   localparam int SIDE_W    = side_bits(MAX_SIDE);
   localparam int ADDR_W    = addr_bits(MAX_SIDE);
   localparam int COUNT_MAX = 2 * MAX_SIDE * MAX_SIDE - 1;
   localparam int CNT_W     = $clog2(COUNT_MAX + 1);

   typedef struct packed {
      logic [ADDR_W-1:0]             addr;
      logic [COL_W-1:0]              col;
      logic [COL_W-1:0]              row;
      logic signed [SAMPLE_BITS-1:0] score;
      logic                          err;
      logic                          positive;
      logic                          refine;
   } job_type;

   logic [CFG_W-1:0]              width_reg_ff;
   logic [CFG_W-1:0]              height_reg_ff;
   logic [COL_W-1:0]              col_ff;
   logic [SIDE_W-1:0]             row_ff;
   logic [CNT_W-1:0]              count_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic [COL_W-1:0]              best_col_ff;
   logic [COL_W-1:0]              best_row_ff;
   logic [ADDR_W-1:0]             best_addr_ff;
   logic                          pending_ff;

   logic [SIDE_W-1:0]             w;
   logic [SIDE_W-1:0]             h;
   logic                          accept;
   logic                          wrap0;
   logic [COL_W-1:0]              col0;
   logic [SIDE_W-1:0]             row0;
   logic                          in_map;
   logic [ADDR_W-1:0]             waddr;
   logic                          take;
   logic signed [SAMPLE_BITS-1:0] best_in;
   logic [COL_W-1:0]              best_col_in;
   logic [COL_W-1:0]              best_row_in;
   logic [ADDR_W-1:0]             best_addr_in;
   logic [CNT_W-1:0]              count_in;
   logic [SIDE_W-1:0]             col1;
   logic                          wrap1;
   logic [COL_W-1:0]              col_in;
   logic [SIDE_W-1:0]             row_in;
   logic [2*SIDE_W-1:0]           area;
   job_type                       job;

   function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_W-1:0] r);
      if (int'(r) < SIDE_MIN) begin
         side_of = SIDE_W'(SIDE_MIN);
      end else if (int'(r) > MAX_SIDE) begin
         side_of = SIDE_W'(MAX_SIDE);
      end else begin
         side_of = SIDE_W'(r);
      end
   endfunction

   assign w      = side_of(width_reg_ff);
   assign h      = side_of(height_reg_ff);
   assign full   = job_full | pending_ff;
   assign accept = push & ~full;

   always_comb begin
      // a width shrink since the last item can leave the column out of range
      wrap0 = (SIDE_W'(col_ff) >= w);
      col0  = wrap0 ? '0 : col_ff;
      row0  = (wrap0 && row_ff < SIDE_W'(MAX_SIDE)) ? row_ff + 1'b1 : row_ff;
      in_map = (row0 < h);
      waddr  = ADDR_W'(int'(row0) * MAX_SIDE + int'(col0));
      take   = in_map && (count_ff == '0 || req_sample > best_ff);

      best_in      = take ? req_sample : best_ff;
      best_col_in  = take ? col0 : best_col_ff;
      best_row_in  = take ? COL_W'(row0) : best_row_ff;
      best_addr_in = take ? waddr : best_addr_ff;

      count_in = (count_ff < CNT_W'(COUNT_MAX)) ? count_ff + 1'b1 : count_ff;

      col1   = SIDE_W'(col0) + SIDE_W'(1);
      wrap1  = (col1 >= w);
      col_in = wrap1 ? '0 : COL_W'(col1);
      row_in = (wrap1 && row0 < SIDE_W'(MAX_SIDE)) ? row0 + 1'b1 : row0;

      area = (2*SIDE_W)'(w) * (2*SIDE_W)'(h);

      job.addr     = best_addr_in;
      job.col      = best_col_in;
      job.row      = best_row_in;
      job.score    = best_in;
      job.err      = ((2*SIDE_W+CNT_W)'(count_in) != (2*SIDE_W+CNT_W)'(area));
      job.positive = (best_in > 0);
      job.refine   = job.positive && !job.err
                     && best_col_in > COL_W'(1)
                     && (SIDE_W'(best_col_in) + SIDE_W'(1)) < w
                     && best_row_in > COL_W'(1)
                     && (SIDE_W'(best_row_in) + SIDE_W'(1)) < h;
   end

   assign job_push       = accept & req_last;
   assign job_data       = job;
   assign refine_pending = pending_ff;
   assign store_we       = accept & in_map;
   assign store_waddr    = waddr;
   assign store_wdata    = req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= SIDE_RESET;
         height_reg_ff <= SIDE_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         count_ff      <= '0;
         best_ff       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         best_col_ff   <= '0;
         best_row_ff   <= '0;
         best_addr_ff  <= '0;
         pending_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAP_WIDTH:  width_reg_ff  <= csr_data;
               CSR_MAP_HEIGHT: height_reg_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            if (req_last) begin
               col_ff       <= '0;
               row_ff       <= '0;
               count_ff     <= '0;
               best_ff      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
               best_col_ff  <= '0;
               best_row_ff  <= '0;
               best_addr_ff <= '0;
            end else begin
               col_ff       <= col_in;
               row_ff       <= row_in;
               count_ff     <= count_in;
               best_ff      <= best_in;
               best_col_ff  <= best_col_in;
               best_row_ff  <= best_row_in;
               best_addr_ff <= best_addr_in;
            end
         end
         // hold off new samples until the neighbors of a refined peak are read
         if (job_push && job.refine) begin
            pending_ff <= 1'b1;
         end else if (reads_done) begin
            pending_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/hpqr_back.sv =====
`timescale 1ns / 1ps

module hpqr_back #(
   parameter int MAX_SIDE    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_empty,
   input  logic [hpqr_pkg::job_bits(MAX_SIDE, SAMPLE_BITS)-1:0] job_data,
   output logic                                     job_pop,
   output logic [hpqr_pkg::addr_bits(MAX_SIDE)-1:0] store_raddr,
   input  logic [SAMPLE_BITS-1:0]                   store_rdata,
   output logic                                     reads_done,
   output logic                                     res_push,
   output logic [hpqr_pkg::rsp_bits(SAMPLE_BITS)-1:0] res_data,
   input  logic                                     res_full
);
   import hpqr_pkg::*;

   localparam int COL_W  = col_bits(MAX_SIDE);
   localparam int ADDR_W = addr_bits(MAX_SIDE);
   localparam int QSUM_W = COL_W + QUARTER_W;

   typedef struct packed {
      logic [ADDR_W-1:0]             addr;
      logic [COL_W-1:0]              col;
      logic [COL_W-1:0]              row;
      logic signed [SAMPLE_BITS-1:0] score;
      logic                          err;
      logic                          positive;
      logic                          refine;
   } job_type;

   typedef struct packed {
      logic [QUARTER_W-1:0]          x;
      logic [QUARTER_W-1:0]          y;
      logic signed [SAMPLE_BITS-1:0] score;
      logic                          err;
   } res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_PUSH
   } state_type;

   // neighbor slots in read order
   localparam logic [1:0] NB_RIGHT = 2'd0;
   localparam logic [1:0] NB_LEFT  = 2'd1;
   localparam logic [1:0] NB_DOWN  = 2'd2;
   localparam logic [1:0] NB_UP    = 2'd3;

   state_type                     state_ff;
   logic [1:0]                    idx_ff;
   job_type                       job_ff;
   logic signed [SAMPLE_BITS-1:0] nb_ff [4];

   job_type                       job_in;
   logic [1:0]                    dx;
   logic [1:0]                    dy;
   logic [QSUM_W-1:0]             xsum;
   logic [QSUM_W-1:0]             ysum;
   res_type                       res;

   assign job_in     = job_type'(job_data);
   assign job_pop    = (state_ff == ST_IDLE) && !job_empty;
   assign reads_done = (state_ff == ST_READ) && (idx_ff == NB_UP);
   assign res_push   = (state_ff == ST_PUSH) && !res_full;

   always_comb begin
      case (idx_ff)
         NB_RIGHT: store_raddr = job_ff.addr + ADDR_W'(1);
         NB_LEFT:  store_raddr = job_ff.addr - ADDR_W'(1);
         NB_DOWN:  store_raddr = job_ff.addr + ADDR_W'(MAX_SIDE);
         NB_UP:    store_raddr = job_ff.addr - ADDR_W'(MAX_SIDE);
         default:  store_raddr = job_ff.addr;
      endcase
   end

   always_comb begin
      dx = 2'b00;
      dy = 2'b00;
      if (job_ff.refine) begin
         if (nb_ff[NB_RIGHT] > nb_ff[NB_LEFT]) begin
            dx = 2'b01;
         end else if (nb_ff[NB_RIGHT] < nb_ff[NB_LEFT]) begin
            dx = 2'b11;
         end
         if (nb_ff[NB_DOWN] > nb_ff[NB_UP]) begin
            dy = 2'b01;
         end else if (nb_ff[NB_DOWN] < nb_ff[NB_UP]) begin
            dy = 2'b11;
         end
      end
      xsum = (QSUM_W'(job_ff.col) << 2) + {{(QSUM_W-2){dx[1]}}, dx};
      ysum = (QSUM_W'(job_ff.row) << 2) + {{(QSUM_W-2){dy[1]}}, dy};
      res.x     = job_ff.positive ? xsum[QUARTER_W-1:0] : '0;
      res.y     = job_ff.positive ? ysum[QUARTER_W-1:0] : '0;
      res.score = job_ff.score;
      res.err   = job_ff.err;
   end

   assign res_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= NB_RIGHT;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  job_ff   <= job_in;
                  idx_ff   <= NB_RIGHT;
                  state_ff <= job_in.refine ? ST_READ : ST_PUSH;
               end
            end
            ST_READ: begin
               // read data is registered, so it arrives in the cycle after its address
               if (idx_ff != NB_RIGHT) begin
                  nb_ff[idx_ff - 1'b1] <= store_rdata;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == NB_UP) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               nb_ff[NB_UP] <= store_rdata;
               state_ff     <= ST_PUSH;
            end
            ST_PUSH: begin
               if (!res_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
